// File: rtl/core/ypcb_pkg.sv
// Shared constants, series divisor tables and rounding helpers for the camera basis block.
package ypcb_pkg;

    localparam int ANGLE_FRAC_BITS_DEF  = 7;
    localparam int VECTOR_FRAC_BITS_DEF = 14;

    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    localparam int SIN_TERMS = 5;
    localparam int COS_TERMS = 6;

    // Divisor of the n-th sine series term: (2n)(2n+1).
    function automatic logic [7:0] sin_div(input logic [2:0] n);
        logic [7:0] d;
        unique case (n)
            3'd1:    d = 8'd6;
            3'd2:    d = 8'd20;
            3'd3:    d = 8'd42;
            3'd4:    d = 8'd72;
            3'd5:    d = 8'd110;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

    // Divisor of the n-th cosine series term: (2n-1)(2n).
    function automatic logic [7:0] cos_div(input logic [2:0] n);
        logic [7:0] d;
        unique case (n)
            3'd1:    d = 8'd2;
            3'd2:    d = 8'd12;
            3'd3:    d = 8'd30;
            3'd4:    d = 8'd56;
            3'd5:    d = 8'd90;
            3'd6:    d = 8'd132;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

    // Shift right with rounding half away from zero; low 16 bits returned.
    function automatic logic [15:0] rnd16(input logic signed [63:0] v, input int unsigned sh);
        logic [63:0] m;
        logic [63:0] half;
        logic [63:0] r;
        m = v[63] ? (64'd0 - v) : v;
        if (sh != 0) begin
            half = 64'd1 << (sh - 1);
            m = (m + half) >> sh;
        end
        r = v[63] ? (64'd0 - m) : m;
        return r[15:0];
    endfunction

endpackage

// File: rtl/core/yaw_pitch_camera_basis.sv
// Top level: yaw/pitch accumulation and camera front/right/up vector generation.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------------
//  s_      | in  | s_tvalid / s_tready | s_tdata[31:0]: delta_yaw, delta_pitch
//  m_      | out | m_tvalid / m_tready | m_tdata[159:0]: 8 vector parts, yaw, pitch
//
// One transfer in gives one transfer out. Each result takes two sine/cosine
// evaluations on one shared sequencer, each a radian conversion plus eleven
// series terms, every one through the bit-serial divider at one quotient bit
// per cycle (TW+32 bits, 45 at defaults). Yaw wrap adds or subtracts one full
// turn per step until yaw is in range. s_tready is high only in idle;
// a finished result waits in the output register while the next input is taken,
// and a second result waits for m_tready. Reset (aresetn low, synchronous)
// sets yaw to 270 degrees and pitch to zero.
module yaw_pitch_camera_basis #(
    parameter int ANGLE_FRAC_BITS  = ypcb_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int VECTOR_FRAC_BITS = ypcb_pkg::VECTOR_FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [15:0] delta_yaw, [31:16] delta_pitch
    input  logic [31:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] front_x, [31:16] front_y, [47:32] front_z, [63:48] right_x,
    // [79:64] right_z, [95:80] up_x, [111:96] up_y, [127:112] up_z,
    // [143:128] yaw_now, [158:144] pitch_now, [159] zero
    output logic [159:0] m_tdata
);
    localparam int YAW_W = $clog2(360 << ANGLE_FRAC_BITS);
    localparam int YSW   = ((YAW_W > 16) ? YAW_W : 16) + 2;
    localparam int PW    = $clog2((89 << ANGLE_FRAC_BITS) + 1) + 1;
    localparam int PSW   = ((PW > 16) ? PW : 16) + 1;
    localparam int unsigned S1 = 30 - VECTOR_FRAC_BITS;
    localparam int unsigned S2 = 60 - VECTOR_FRAC_BITS;

    localparam logic signed [YSW-1:0] FULL_S  = YSW'(360 << ANGLE_FRAC_BITS);
    localparam logic [YAW_W-1:0]      YAW_RST = YAW_W'(270 << ANGLE_FRAC_BITS);
    localparam logic signed [PSW-1:0] LIM_S   = PSW'(89 << ANGLE_FRAC_BITS);

    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_WRAP  = 3'd1;
    localparam logic [2:0] T_YAW   = 3'd2;
    localparam logic [2:0] T_PITCH = 3'd3;
    localparam logic [2:0] T_MUL   = 3'd4;
    localparam logic [2:0] T_RND   = 3'd5;
    localparam logic [2:0] T_FIN   = 3'd6;

    logic [2:0]            state_reg;
    logic [YAW_W-1:0]      yaw_reg;
    logic signed [PW-1:0]  pitch_reg;
    logic signed [YSW-1:0] ysum_reg;
    logic signed [31:0]    sy_reg, cy_reg, sp_reg, cp_reg;
    logic signed [63:0]    prod_reg;
    logic [1:0]            k_reg;
    logic [15:0]           fx_reg, fy_reg, fz_reg, rx_reg, rz_reg, ux_reg, uy_reg, uz_reg;
    logic                  m_valid_reg;
    logic [159:0]          m_data_reg;

    logic                  s_acc;
    logic signed [PSW-1:0] psum;
    logic signed [PSW-1:0] pclamp;
    logic signed [PW-1:0]  p_abs;
    logic                  sc_start;
    logic [YAW_W-1:0]      sc_angle;
    logic                  sc_done;
    logic signed [31:0]    sc_sin, sc_cos;
    logic signed [31:0]    sp_signed;
    logic signed [31:0]    mul_a, mul_b;
    logic [15:0]           rnd_p;
    logic signed [31:0]    pitch_ext;
    logic [31:0]           yaw_ext;
    logic                  ysum_neg, ysum_big;
    logic                  out_free;

    assign s_tready = (state_reg == T_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        psum = PSW'(pitch_reg) + PSW'($signed(s_tdata[31:16]));
        priority if (psum > LIM_S) begin
            pclamp = LIM_S;
        end else if (psum < -LIM_S) begin
            pclamp = -LIM_S;
        end else begin
            pclamp = psum;
        end

        ysum_neg = ysum_reg[YSW-1];
        ysum_big = (ysum_reg >= FULL_S);
        p_abs    = pitch_reg[PW-1] ? -pitch_reg : pitch_reg;

        // one sincos sequencer serves yaw first, then |pitch|
        sc_start = 1'b0;
        sc_angle = ysum_reg[YAW_W-1:0];
        if (state_reg == T_WRAP && !ysum_neg && !ysum_big) begin
            sc_start = 1'b1;
        end else if (state_reg == T_YAW && sc_done) begin
            sc_start = 1'b1;
            sc_angle = YAW_W'($unsigned(p_abs));
        end

        sp_signed = pitch_reg[PW-1] ? -sc_sin : sc_sin;

        unique case (k_reg)
            2'd0: begin mul_a = cy_reg; mul_b = cp_reg; end
            2'd1: begin mul_a = sy_reg; mul_b = cp_reg; end
            2'd2: begin mul_a = cy_reg; mul_b = sp_reg; end
            2'd3: begin mul_a = sy_reg; mul_b = sp_reg; end
            default: begin mul_a = cy_reg; mul_b = cp_reg; end
        endcase

        rnd_p     = ypcb_pkg::rnd16(prod_reg, S2);
        pitch_ext = 32'(pitch_reg);
        yaw_ext   = 32'(yaw_reg);
    end

    ypcb_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .AW(YAW_W)) u_sincos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sc_start),
        .angle   (sc_angle),
        .done    (sc_done),
        .sin_q   (sc_sin),
        .cos_q   (sc_cos)
    );

    // control and stored orientation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            yaw_reg     <= YAW_RST;
            pitch_reg   <= '0;
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
        end else begin
            // a result loaded in T_FIN keeps the valid set
            if (m_valid_reg && m_tready && state_reg != T_FIN) m_valid_reg <= 1'b0;
            unique case (state_reg)
                T_IDLE: begin
                    if (s_acc) begin
                        pitch_reg <= PW'(pclamp);
                        state_reg <= T_WRAP;
                    end
                end
                T_WRAP: begin
                    if (!ysum_neg && !ysum_big) begin
                        yaw_reg   <= ysum_reg[YAW_W-1:0];
                        state_reg <= T_YAW;
                    end
                end
                T_YAW:   if (sc_done) state_reg <= T_PITCH;
                T_PITCH: begin
                    if (sc_done) begin
                        k_reg     <= 2'd0;
                        state_reg <= T_MUL;
                    end
                end
                T_MUL: state_reg <= T_RND;
                T_RND: begin
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= (k_reg == 2'd3) ? T_FIN : T_MUL;
                end
                T_FIN: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            ysum_reg <= YSW'(yaw_reg) + YSW'($signed(s_tdata[15:0]));
        end else if (state_reg == T_WRAP) begin
            if (ysum_neg) ysum_reg <= ysum_reg + FULL_S;
            else if (ysum_big) ysum_reg <= ysum_reg - FULL_S;
        end
        if (state_reg == T_YAW && sc_done) begin
            sy_reg <= sc_sin;
            cy_reg <= sc_cos;
            rx_reg <= 16'd0 - ypcb_pkg::rnd16(64'(sc_sin), S1);
            rz_reg <= ypcb_pkg::rnd16(64'(sc_cos), S1);
        end
        if (state_reg == T_PITCH && sc_done) begin
            sp_reg <= sp_signed;
            cp_reg <= sc_cos;
            fy_reg <= ypcb_pkg::rnd16(64'(sp_signed), S1);
            uy_reg <= ypcb_pkg::rnd16(64'(sc_cos), S1);
        end
        if (state_reg == T_MUL) begin
            prod_reg <= mul_a * mul_b;
        end
        if (state_reg == T_RND) begin
            // rounding is symmetric, so negated products negate after rounding
            unique case (k_reg)
                2'd0: fx_reg <= rnd_p;
                2'd1: fz_reg <= rnd_p;
                2'd2: ux_reg <= 16'd0 - rnd_p;
                2'd3: uz_reg <= 16'd0 - rnd_p;
                default: fx_reg <= rnd_p;
            endcase
        end
        if (state_reg == T_FIN && out_free) begin
            m_data_reg <= {1'b0, pitch_ext[14:0], yaw_ext[15:0], uz_reg, uy_reg, ux_reg,
                           rz_reg, rx_reg, fz_reg, fy_reg, fx_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
endmodule

// File: rtl/core/ypcb_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module ypcb_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] work_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0] rem_sh;
    logic [DEN_W:0] rem_diff;
    logic           ge;

    always_comb begin
        rem_sh   = {rem_reg, work_reg[NUM_W-1]};
        rem_diff = rem_sh - {1'b0, den_reg};
        ge       = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // numerator shifts out at the top while quotient bits shift in below
    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end else if (busy_reg) begin
            work_reg <= {work_reg[NUM_W-2:0], ge};
            rem_reg  <= ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = work_reg;
endmodule

// File: rtl/core/ypcb_sincos.sv
// Sine/cosine sequencer: octant reduction, radian conversion and Taylor series, Q30.
module ypcb_sincos #(
    parameter int ANGLE_FRAC_BITS = ypcb_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int AW = $clog2(360 << ANGLE_FRAC_BITS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [AW-1:0]       angle,
    output logic                done,
    output logic signed [31:0]  sin_q,
    output logic signed [31:0]  cos_q
);
    localparam int TW    = $clog2((45 << ANGLE_FRAC_BITS) + 1);
    localparam int NUM_W = TW + 32;
    localparam int DEN_W = $clog2((180 << ANGLE_FRAC_BITS) + 1);
    localparam logic [AW-1:0]    QTR  = AW'(90 << ANGLE_FRAC_BITS);
    localparam logic [AW-1:0]    HALF = AW'(180 << ANGLE_FRAC_BITS);
    localparam logic [AW-1:0]    TQTR = AW'(270 << ANGLE_FRAC_BITS);
    localparam logic [AW-1:0]    OCT  = AW'(45 << ANGLE_FRAC_BITS);
    localparam logic [DEN_W-1:0] RDEN = DEN_W'(180 << ANGLE_FRAC_BITS);

    localparam logic [2:0] SC_IDLE = 3'd0;
    localparam logic [2:0] SC_RAD  = 3'd1;
    localparam logic [2:0] SC_X2   = 3'd2;
    localparam logic [2:0] SC_MUL  = 3'd3;
    localparam logic [2:0] SC_DIVS = 3'd4;
    localparam logic [2:0] SC_DIV  = 3'd5;
    localparam logic [2:0] SC_DONE = 3'd6;

    logic [2:0]         state_reg;
    logic [1:0]         quad_reg;
    logic               swap_reg;
    logic               phase_reg;
    logic [2:0]         n_reg;
    logic [29:0]        x_reg;
    logic [29:0]        x2_reg;
    logic [30:0]        term_reg;
    logic [60:0]        prod_reg;
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;
    logic signed [31:0] s_out_reg;
    logic signed [31:0] c_out_reg;
    logic               done_reg;

    logic [1:0]       quad;
    logic [AW-1:0]    resid;
    logic [TW-1:0]    t_red;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_go;
    logic             div_done;
    logic [NUM_W-1:0] div_quo;
    logic [59:0]      xx;
    logic [7:0]       sdiv;
    logic signed [31:0] term_s;
    logic signed [31:0] s0;
    logic signed [31:0] c0;

    always_comb begin
        priority if (angle >= TQTR) begin
            quad  = 2'd3;
            resid = angle - TQTR;
        end else if (angle >= HALF) begin
            quad  = 2'd2;
            resid = angle - HALF;
        end else if (angle >= QTR) begin
            quad  = 2'd1;
            resid = angle - QTR;
        end else begin
            quad  = 2'd0;
            resid = angle;
        end
        t_red = (resid > OCT) ? TW'(QTR - resid) : TW'(resid);

        sdiv    = phase_reg ? ypcb_pkg::cos_div(n_reg) : ypcb_pkg::sin_div(n_reg);
        div_go  = 1'b0;
        div_num = NUM_W'(prod_reg >> 30);
        div_den = DEN_W'(sdiv);
        if (state_reg == SC_IDLE) begin
            div_go  = start;
            div_num = NUM_W'(t_red) * NUM_W'(ypcb_pkg::PI_Q30) + NUM_W'(RDEN >> 1);
            div_den = RDEN;
        end else if (state_reg == SC_DIVS) begin
            div_go = 1'b1;
        end

        xx     = 60'(x_reg) * 60'(x_reg);
        term_s = $signed({1'b0, div_quo[30:0]});
        s0     = swap_reg ? cos_reg : sin_reg;
        c0     = swap_reg ? sin_reg : cos_reg;
    end

    ypcb_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_go),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                SC_IDLE: if (start) state_reg <= SC_RAD;
                SC_RAD:  if (div_done) state_reg <= SC_X2;
                SC_X2:   state_reg <= SC_MUL;
                SC_MUL:  state_reg <= SC_DIVS;
                SC_DIVS: state_reg <= SC_DIV;
                SC_DIV: begin
                    if (div_done) begin
                        if (phase_reg && n_reg == 3'(ypcb_pkg::COS_TERMS)) begin
                            state_reg <= SC_DONE;
                        end else begin
                            state_reg <= SC_MUL;
                        end
                    end
                end
                SC_DONE: begin
                    state_reg <= SC_IDLE;
                    done_reg  <= 1'b1;
                end
                default: state_reg <= SC_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == SC_IDLE && start) begin
            quad_reg <= quad;
            swap_reg <= (resid > OCT);
        end
        if (state_reg == SC_RAD && div_done) begin
            x_reg <= div_quo[29:0];
        end
        if (state_reg == SC_X2) begin
            x2_reg    <= xx[59:30];
            term_reg  <= {1'b0, x_reg};
            sin_reg   <= $signed({2'b00, x_reg});
            phase_reg <= 1'b0;
            n_reg     <= 3'd1;
        end
        if (state_reg == SC_MUL) begin
            prod_reg <= 61'(term_reg) * 61'(x2_reg);
        end
        if (state_reg == SC_DIV && div_done) begin
            if (!phase_reg) begin
                sin_reg <= n_reg[0] ? sin_reg - term_s : sin_reg + term_s;
            end else begin
                cos_reg <= n_reg[0] ? cos_reg - term_s : cos_reg + term_s;
            end
            if (!phase_reg && n_reg == 3'(ypcb_pkg::SIN_TERMS)) begin
                // sine done; cosine series starts from one
                phase_reg <= 1'b1;
                n_reg     <= 3'd1;
                term_reg  <= ypcb_pkg::ONE_Q30;
                cos_reg   <= $signed({1'b0, ypcb_pkg::ONE_Q30});
            end else begin
                n_reg    <= n_reg + 1'b1;
                term_reg <= div_quo[30:0];
            end
        end
        if (state_reg == SC_DONE) begin
            unique case (quad_reg)
                2'd0: begin s_out_reg <= s0;  c_out_reg <= c0;  end
                2'd1: begin s_out_reg <= c0;  c_out_reg <= -s0; end
                2'd2: begin s_out_reg <= -s0; c_out_reg <= -c0; end
                2'd3: begin s_out_reg <= -c0; c_out_reg <= s0;  end
                default: begin s_out_reg <= s0; c_out_reg <= c0; end
            endcase
        end
    end

    assign done  = done_reg;
    assign sin_q = s_out_reg;
    assign cos_q = c_out_reg;
endmodule

// File: rtl/core/ypcb_checker.sv
// Port-level checker for the camera basis block, bound to the top level.
module ypcb_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata
);
    // one item in flight: an accepted transfer closes the input side
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result dropped or changed");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[159])
        else $error("pad bit of result set");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
endmodule

bind yaw_pitch_camera_basis ypcb_checker u_ypcb_checker (.*);

// File: tb/sv/tb.sv
// Testbench for yaw_pitch_camera_basis: random and corner yaw/pitch updates vs. a predictor.
module tb;

    localparam int AF = ypcb_pkg::ANGLE_FRAC_BITS_DEF;
    localparam int VF = ypcb_pkg::VECTOR_FRAC_BITS_DEF;
    localparam longint FULL_TURN = longint'(360) << AF;
    localparam longint PITCH_LIM = longint'(89) << AF;
    localparam longint QUARTER   = longint'(90) << AF;
    localparam longint EIGHTH    = longint'(45) << AF;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // [15:0] delta_yaw, [31:16] delta_pitch
    logic [31:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // [15:0] front_x ... [143:128] yaw_now, [158:144] pitch_now, [159] zero
    logic [159:0] m_tdata;

    yaw_pitch_camera_basis u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Camera orientation predictor plus queue of pending basis results.
    class basis_scoreboard;
        longint         yaw_acc;
        longint         pitch_acc;
        logic [159:0]   basis_q[$];
        int             mismatches;

        function new();
            yaw_acc    = longint'(270) << AF;
            pitch_acc  = 0;
            mismatches = 0;
        endfunction

        // degrees-in-units (0..45) -> radians Q30
        function longint unsigned rad_q30(longint t);
            longint unsigned den;
            den = longint'(180) << AF;
            return (longint'(t) * 64'd3373259426 + den / 2) / den;
        endfunction

        function longint taylor(longint unsigned x, bit want_cos);
            longint unsigned x2, term;
            longint sum;
            int k;
            x2 = (x * x) >> 30;
            term = want_cos ? (64'd1 << 30) : x;
            sum = longint'(term);
            for (k = 1; k <= (want_cos ? 6 : 5); k++) begin
                term = ((term * x2) >> 30) /
                       (want_cos ? (2*k-1)*(2*k) : (2*k)*(2*k+1));
                if (k & 1) sum -= longint'(term);
                else       sum += longint'(term);
            end
            return sum;
        endfunction

        task sin_cos(input longint a, output longint s, output longint c);
            longint q, r, s0, c0;
            longint unsigned x;
            q = a / QUARTER;
            r = a - q * QUARTER;
            if (r <= EIGHTH) begin
                x = rad_q30(r);
                s0 = taylor(x, 0);
                c0 = taylor(x, 1);
            end else begin
                // past 45 degrees: use the complement, sine and cosine swap
                x = rad_q30(QUARTER - r);
                s0 = taylor(x, 1);
                c0 = taylor(x, 0);
            end
            case (q & 3)
                0: begin s = s0;  c = c0;  end
                1: begin s = c0;  c = -s0; end
                2: begin s = -s0; c = -c0; end
                default: begin s = -c0; c = s0; end
            endcase
        endtask

        function logic [15:0] round_out(longint v, int sh);
            longint unsigned mag;
            longint res;
            mag = (v < 0) ? longint'(-v) : v;
            if (sh > 0) mag = (mag + (64'd1 << (sh - 1))) >> sh;
            res = (v < 0) ? -longint'(mag) : longint'(mag);
            return res[15:0];
        endfunction

        // Accepted input transfer: advance angles, queue the expected basis.
        task note_input(input logic [31:0] d);
            longint y, p, sy, cy, sp, cp;
            int s1, s2;
            logic [159:0] e;
            s1 = 30 - VF;
            s2 = 60 - VF;
            y = yaw_acc + longint'($signed(d[15:0]));
            p = pitch_acc + longint'($signed(d[31:16]));
            y = y % FULL_TURN;
            if (y < 0) y += FULL_TURN;
            if (p > PITCH_LIM)  p = PITCH_LIM;
            if (p < -PITCH_LIM) p = -PITCH_LIM;
            yaw_acc = y;
            pitch_acc = p;
            sin_cos(y, sy, cy);
            sin_cos(p < 0 ? -p : p, sp, cp);
            if (p < 0) sp = -sp;
            e = '0;
            e[15:0]    = round_out(cy * cp, s2);
            e[31:16]   = round_out(sp, s1);
            e[47:32]   = round_out(sy * cp, s2);
            e[63:48]   = round_out(-sy, s1);
            e[79:64]   = round_out(cy, s1);
            e[95:80]   = round_out(-(cy * sp), s2);
            e[111:96]  = round_out(cp, s1);
            e[127:112] = round_out(-(sy * sp), s2);
            e[143:128] = y[15:0];
            e[158:144] = p[14:0];
            basis_q.push_back(e);
        endtask

        task report(input string what, input logic [15:0] got, input logic [15:0] want);
            $display("mismatch %s: got %h expected %h", what, got, want);
            mismatches++;
        endtask

        // Accepted output transfer: compare against the oldest expectation.
        task check_result(input logic [159:0] r);
            logic [159:0] e;
            string names[10];
            int i;
            names = '{"front_x", "front_y", "front_z", "right_x", "right_z",
                      "up_x", "up_y", "up_z", "yaw_now", "pitch_now"};
            if (basis_q.size() == 0) begin
                report("unexpected transfer", r[15:0], 16'h0);
                return;
            end
            e = basis_q.pop_front();
            for (i = 0; i < 10; i++)
                if (r[16*i +: 16] !== e[16*i +: 16])
                    report(names[i], r[16*i +: 16], e[16*i +: 16]);
        endtask
    endclass

    basis_scoreboard sb;
    int sender_idle_pct;
    int receiver_idle_pct;
    int receiver_hold;      // cycles the receiver refuses outright

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Absolute limit: well over ten times the worst-case run time of all items.
    initial begin
        #300_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random stalls, plus a forced long hold when requested.
    initial begin
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (receiver_hold > 0) begin
                receiver_hold <= receiver_hold - 1;
                m_tready <= 0;
            end else begin
                m_tready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    // Monitor both channels at the clock edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_input(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    // Offer one input transfer, with random idle cycles before it.
    task send_delta(input logic [15:0] dyaw, input logic [15:0] dpitch);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {dpitch, dyaw};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    task drain();
        s_tvalid <= 0;
        while (sb.basis_q.size() != 0) @(posedge aclk);
    endtask

    task random_delta();
        logic [15:0] dy, dp;
        case ($urandom_range(3))
            0: begin dy = 16'($urandom); dp = 16'($urandom); end
            1: begin
                dy = 16'($urandom_range(1024) - 512);
                dp = 16'($urandom_range(512) - 256);
            end
            2: begin
                dy = 16'($urandom_range(46080) - 23040);
                dp = 16'($urandom_range(2000) - 1000);
            end
            default: begin dy = 16'($urandom_range(64) - 32); dp = 16'($urandom); end
        endcase
        send_delta(dy, dp);
    endtask

    initial begin
        int i;
        sb = new();
        sender_idle_pct   = 17;
        receiver_idle_pct = 78;
        receiver_hold     = 0;
        aresetn  = 0;
        s_tvalid = 0;
        s_tdata  = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1;

        // Directed: zero step from reset, field extremes, saturation, wraps.
        send_delta(16'd0, 16'd0);
        send_delta(16'h7fff, 16'h7fff);   // pitch saturates high
        send_delta(16'h8000, 16'h8000);   // pitch saturates low, yaw back
        send_delta(16'hffff, 16'h0001);
        send_delta(16'd0, 16'sd11392);    // pitch to one unit above zero from just above -89
        send_delta(16'd0, 16'sd5760);     // pitch one unit past 45 degrees
        send_delta(16'd0, -16'sd11520);   // pitch one unit short of -45
        send_delta(16'd0, 16'sd5761);
        send_delta(-16'sd23040, 16'sd0);  // yaw two units below 90
        send_delta(16'sd5760, 16'sd0);    // yaw two units below 135
        send_delta(16'sd5760, 16'sd0);    // yaw two units below 180
        send_delta(16'sd11520, 16'sd0);   // yaw two units below 270
        send_delta(16'sd11519, 16'sd0);   // yaw three units below 360
        send_delta(16'sd1, 16'sd0);       // yaw two units below 360, no wrap
        send_delta(-16'sd1, 16'sd0);      // yaw back to three units below 360
        send_delta(16'sd5761, 16'sd1);    // yaw wraps past 360 to two units below 45
        send_delta(16'h7fff, 16'h0000);
        send_delta(16'h8000, 16'h0000);
        drain();

        // Long receiver hold while the sender keeps offering: block must stall.
        receiver_hold = 6000;
        for (i = 0; i < 6; i++) random_delta();
        drain();

        for (i = 0; i < 500; i++) random_delta();
        sender_idle_pct = 78;
        receiver_idle_pct = 17;
        for (i = 0; i < 500; i++) random_delta();
        drain();                          // sender pauses until all results are in
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        for (i = 0; i < 480; i++) random_delta();
        s_tvalid <= 0;

        i = 0;
        while (sb.basis_q.size() != 0 && i < 2_000_000) begin
            @(posedge aclk);
            i++;
        end
        repeat (3000) @(posedge aclk);
        if (sb.basis_q.size() == 0 && sb.mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
